// ----- sv/cip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cip_pkg
// Shared types, opcodes and the length table of the instruction predecoder.
// ----------------------------------------------------------------------------
package cip_pkg;

    typedef enum logic [2:0] {
        FK_ORDINARY      = 3'd0,
        FK_CALL          = 3'd1,
        FK_JUMP          = 3'd2,
        FK_BRANCH_ALWAYS = 3'd3,
        FK_COND_BRANCH   = 3'd4,
        FK_RETURN        = 3'd5,
        FK_STOP          = 3'd6
    } flow_kind_t;

    localparam int PC_W        = 22;
    localparam int ROM_W       = 23;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 32;
    localparam int PADDR_W     = 3;

    localparam logic [ROM_W-1:0] ROM_BYTES_RESET = 23'h40_0000;
    localparam logic             REG_ROM_BYTES   = 1'b0;

    localparam logic [PC_W-1:0] VECTOR_LO = 22'h00_7FB0;
    localparam logic [PC_W-1:0] VECTOR_HI = 22'h00_7FFF;
    localparam logic [7:0]      MAP_BANK_LIMIT = 8'h7E;

    localparam logic [7:0] OP_BRK = 8'h00;
    localparam logic [7:0] OP_JSR = 8'h20;
    localparam logic [7:0] OP_JSL = 8'h22;
    localparam logic [7:0] OP_JMP = 8'h4C;
    localparam logic [7:0] OP_JML = 8'h5C;
    localparam logic [7:0] OP_BRA = 8'h80;
    localparam logic [7:0] OP_BPL = 8'h10;
    localparam logic [7:0] OP_BNE = 8'hD0;
    localparam logic [7:0] OP_BEQ = 8'hF0;
    localparam logic [7:0] OP_RTS = 8'h60;
    localparam logic [7:0] OP_RTL = 8'h6B;
    localparam logic [7:0] OP_REP = 8'hC2;
    localparam logic [7:0] OP_SEP = 8'hE2;

    localparam int BIT_M = 5;   // accumulator width bit in REP/SEP mask
    localparam int BIT_X = 4;   // index width bit

    typedef struct packed {
        logic [PC_W-1:0] pc_offset;
        logic [7:0]      opcode;
        logic [7:0]      operand_one;
        logic [7:0]      operand_two;
        logic [7:0]      operand_three;
        logic            path_start;
    } cip_item_t;

    typedef struct packed {
        logic [2:0]      length;
        flow_kind_t      flow_kind;
        logic [PC_W-1:0] target_offset;
        logic            target_valid;
        logic            ends_path;
        logic            wide_acc_after;
        logic            wide_index_after;
    } cip_result_t;

    function automatic logic [2:0] length_of(input logic [7:0] op,
                                             input logic wide_a,
                                             input logic wide_x);
        logic [2:0] len;
        begin
            case (op)
                8'hA9, 8'hE9, 8'h29, 8'h09:
                    len = wide_a ? 3'd3 : 3'd2;
                8'hA2, 8'hA0, 8'hE0:
                    len = wide_x ? 3'd3 : 3'd2;
                8'h8F, 8'h22, 8'h5C, 8'h9F, 8'hFF, 8'h0F, 8'h6F, 8'hAF:
                    len = 3'd4;
                8'h9C, 8'h8D, 8'hAD, 8'h20, 8'h4C, 8'hCD, 8'h9D, 8'hBD,
                8'h9E, 8'hDC, 8'hF4, 8'h8E, 8'hAE, 8'hBE:
                    len = 3'd3;
                8'hC2, 8'hE2, 8'h64, 8'h85, 8'h80, 8'h10, 8'hE6, 8'h84,
                8'h92, 8'h74, 8'h94, 8'hA5, 8'h91, 8'hB7, 8'hA4, 8'h03,
                8'h01, 8'h05, 8'h65, 8'h26, 8'h07, 8'h15, 8'h43, 8'h86,
                8'h96, 8'h97, 8'hD1, 8'hA1, 8'h87, 8'h37:
                    len = 3'd2;
                default:
                    len = 3'd1;
            endcase
            return len;
        end
    endfunction

endpackage

// ----- sv/cpu_instruction_predecoder.sv -----
`timescale 1ns / 1ps
// A request passes through the input register, then the result register.
// Throughput: one request per cycle unless stalled; registered mode bits feed the next decode.
// Both stages advance together unless the result register is held by m_axis_tready low.
// Reset (rst_n low, asynchronous): stages empty, both width modes 8-bit,
// rom_bytes = 4194304.
// ----------------------------------------------------------------------------
// cpu_instruction_predecoder
// 65816 instruction length and control-flow predecoder with APB config port.
// ----------------------------------------------------------------------------
module cpu_instruction_predecoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request: pc_offset[21:0], opcode[29:22], operand_one[37:30],
    //          operand_two[45:38], operand_three[53:46], zero pad[55:54]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cip_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tuser,   // path_start[0]
    // result: length[2:0], target_offset[24:3], target_valid[25], ends_path[26],
    //         wide_acc_after[27], wide_index_after[28], zero pad[31:29]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cip_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [2:0]                      m_axis_tuser,   // flow_kind[2:0]
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cip_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic                           in_valid_reg;
    cip_pkg::cip_item_t             in_item_reg;
    logic                           out_valid_reg;
    cip_pkg::cip_result_t           out_res_reg;
    logic                           wide_acc_reg;
    logic                           wide_idx_reg;
    logic [cip_pkg::ROM_W-1:0]      rom_bytes_reg;
    logic [cip_pkg::ROM_W-1:0]      rom_bytes_next;
    cip_pkg::cip_item_t             in_item_next;
    cip_pkg::cip_result_t           dec_res;
    logic                           out_free;
    logic                           advance;
    logic                           take_in;
    logic                           reg_sel;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    assign in_item_next.pc_offset     = s_axis_tdata[21:0];
    assign in_item_next.opcode        = s_axis_tdata[29:22];
    assign in_item_next.operand_one   = s_axis_tdata[37:30];
    assign in_item_next.operand_two   = s_axis_tdata[45:38];
    assign in_item_next.operand_three = s_axis_tdata[53:46];
    assign in_item_next.path_start    = s_axis_tuser;

    cip_decode u_decode
    (
        .item      (in_item_reg),
        .wide_acc  (wide_acc_reg),
        .wide_idx  (wide_idx_reg),
        .rom_bytes (rom_bytes_reg),
        .res       (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wide_acc_reg  <= 1'b0;
            wide_idx_reg  <= 1'b0;
            rom_bytes_reg <= cip_pkg::ROM_BYTES_RESET;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                wide_acc_reg  <= dec_res.wide_acc_after;
                wide_idx_reg  <= dec_res.wide_index_after;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            rom_bytes_reg <= rom_bytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            in_item_reg <= in_item_next;
        if (advance)
            out_res_reg <= dec_res;
    end

    // config register
    assign reg_sel = (paddr[2] == cip_pkg::REG_ROM_BYTES);
    assign pready  = 1'b1;

    always_comb
    begin
        rom_bytes_next = rom_bytes_reg;
        if (psel && penable && pwrite && pready && reg_sel)
            rom_bytes_next = pwdata[cip_pkg::ROM_W-1:0];
    end

    assign prdata = reg_sel ? {{(32 - cip_pkg::ROM_W){1'b0}}, rom_bytes_reg} : 32'd0;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            out_res_reg.wide_index_after,
                            out_res_reg.wide_acc_after,
                            out_res_reg.ends_path,
                            out_res_reg.target_valid,
                            out_res_reg.target_offset,
                            out_res_reg.length};
    assign m_axis_tuser  = out_res_reg.flow_kind;

endmodule

// ----- sv/cip_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cip_decode
// Single-pass decode of one instruction window: length, flow kind, mapped
// target and the updated width mode bits.
// ----------------------------------------------------------------------------
module cip_decode
(
    input  cip_pkg::cip_item_t           item,
    input  logic                         wide_acc,
    input  logic                         wide_idx,
    input  logic [cip_pkg::ROM_W-1:0]    rom_bytes,
    output cip_pkg::cip_result_t         res
);

    logic                      wa0;
    logic                      wx0;
    logic                      is_stop;
    logic                      is_call_jump;
    logic                      is_long;
    logic                      is_branch;
    logic                      is_return;
    logic [7:0]                bank;
    logic [15:0]               low;
    logic                      jmp_mapped;
    logic [cip_pkg::PC_W-1:0]  jmp_target;
    logic [14:0]               br_low;
    logic [cip_pkg::PC_W-1:0]  br_target;
    logic                      below_rom;

    // path start drops both modes to 8-bit before anything else
    assign wa0 = item.path_start ? 1'b0 : wide_acc;
    assign wx0 = item.path_start ? 1'b0 : wide_idx;

    assign is_stop = ((item.pc_offset >= cip_pkg::VECTOR_LO) &&
                      (item.pc_offset <= cip_pkg::VECTOR_HI)) ||
                     (item.opcode == cip_pkg::OP_BRK);
    assign is_long = (item.opcode == cip_pkg::OP_JSL) || (item.opcode == cip_pkg::OP_JML);
    assign is_call_jump = is_long || (item.opcode == cip_pkg::OP_JSR) ||
                          (item.opcode == cip_pkg::OP_JMP);
    assign is_branch = (item.opcode == cip_pkg::OP_BRA) || (item.opcode == cip_pkg::OP_BPL) ||
                       (item.opcode == cip_pkg::OP_BNE) || (item.opcode == cip_pkg::OP_BEQ);
    assign is_return = (item.opcode == cip_pkg::OP_RTS) || (item.opcode == cip_pkg::OP_RTL);

    // LoROM-style mapping; low half of banks below 0x7E is not ROM
    assign bank = is_long ? item.operand_three : 8'h00;
    assign low  = {item.operand_two, item.operand_one};
    assign jmp_mapped = low[15] || (bank >= cip_pkg::MAP_BANK_LIMIT);
    assign jmp_target = jmp_mapped ? {bank[6:0], low[14:0]} : '0;

    // branch wraps within the current 32 KiB page
    assign br_low = item.pc_offset[14:0] + 15'd2 + {{7{item.operand_one[7]}}, item.operand_one};
    assign br_target = {item.pc_offset[cip_pkg::PC_W-1:15], br_low};

    always_comb
    begin
        res.length           = 3'd1;
        res.flow_kind        = cip_pkg::FK_ORDINARY;
        res.target_offset    = '0;
        res.target_valid     = 1'b0;
        res.ends_path        = 1'b0;
        res.wide_acc_after   = wa0;
        res.wide_index_after = wx0;
        below_rom = 1'b0;
        if (is_stop)
        begin
            res.length    = 3'd0;
            res.flow_kind = cip_pkg::FK_STOP;
            res.ends_path = 1'b1;
        end
        else if (is_call_jump)
        begin
            res.length = is_long ? 3'd4 : 3'd3;
            if ((item.opcode == cip_pkg::OP_JSR) || (item.opcode == cip_pkg::OP_JSL))
            begin
                res.flow_kind = cip_pkg::FK_CALL;
            end
            else
            begin
                res.flow_kind = cip_pkg::FK_JUMP;
                res.ends_path = 1'b1;
            end
            res.target_offset = jmp_target;
            below_rom = {1'b0, jmp_target} < rom_bytes;
            res.target_valid = jmp_mapped && below_rom;
        end
        else if (is_branch)
        begin
            res.length = 3'd2;
            if (item.opcode == cip_pkg::OP_BRA)
            begin
                res.flow_kind = cip_pkg::FK_BRANCH_ALWAYS;
                res.ends_path = 1'b1;
            end
            else
            begin
                res.flow_kind = cip_pkg::FK_COND_BRANCH;
            end
            res.target_offset = br_target;
            below_rom = {1'b0, br_target} < rom_bytes;
            res.target_valid = below_rom;
        end
        else if (is_return)
        begin
            res.flow_kind = cip_pkg::FK_RETURN;
            res.ends_path = 1'b1;
        end
        else
        begin
            res.length = cip_pkg::length_of(item.opcode, wa0, wx0);
            if (item.opcode == cip_pkg::OP_REP)
            begin
                if (item.operand_one[cip_pkg::BIT_M]) res.wide_acc_after   = 1'b1;
                if (item.operand_one[cip_pkg::BIT_X]) res.wide_index_after = 1'b1;
            end
            else if (item.opcode == cip_pkg::OP_SEP)
            begin
                if (item.operand_one[cip_pkg::BIT_M]) res.wide_acc_after   = 1'b0;
                if (item.operand_one[cip_pkg::BIT_X]) res.wide_index_after = 1'b0;
            end
        end
    end

endmodule

// ----- sv/cip_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cip_checker
// Port-level checks on the predecoder result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cip_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [cip_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic [2:0]                      m_axis_tuser,
    input  logic                            pready
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // stop: zero length and path ends
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == cip_pkg::FK_STOP) |->
            (m_axis_tdata[2:0] == 3'd0) && m_axis_tdata[26])
        else $error("stop result with nonzero length or open path");

    // only calls, jumps and branches carry a target
    a_target: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == cip_pkg::FK_ORDINARY) ||
                          (m_axis_tuser == cip_pkg::FK_RETURN) ||
                          (m_axis_tuser == cip_pkg::FK_STOP)) |->
            !m_axis_tdata[25] && (m_axis_tdata[24:3] == 22'd0))
        else $error("target on a kind without one");

    // one result per request: when neither side is active across the checked sequence, nothing is left in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) ##1
        !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result without request");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind cpu_instruction_predecoder cip_checker u_cip_checker (.*);
